@@ design/tdec_pkg.sv @@
package tdec_pkg;

  localparam int MASS_W     = 16;
  localparam int RADIUS_W   = 23;
  localparam int TSTEP_W    = 8;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MASS_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd4;

  // Shared unit operations
  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

endpackage

@@ design/tdec_alu.sv @@
// Shared multi-cycle unit: signed shift-add multiply-accumulate, or
// unsigned restoring divide. One bit per cycle.
module tdec_alu #(
  parameter int AW = 96,
  parameter int MW = 26
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tdec_pkg::alu_req_t      req,
  input  logic [AW-1:0]           opa,
  input  logic [AW-1:0]           opb,
  input  logic [AW-1:0]           acc_in,
  output logic [AW-1:0]           result,
  output logic                    done
);
  import tdec_pkg::*;

  localparam int CW = $clog2(AW);
  localparam logic [CW-1:0] MUL_LAST = CW'(MW - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(AW - 1);

  logic          busy;
  alu_op_t       op_q;
  logic [CW-1:0] cnt;
  logic [AW-1:0] acc;
  logic [AW-1:0] mcand;
  logic [MW-1:0] mplier;
  logic [AW-1:0] dvd;
  logic [AW-1:0] dsr;
  logic [AW:0]   rem;
  logic [AW-1:0] quo;

  logic [AW-1:0] addend;
  logic [AW:0]   rem_sh;
  logic [AW+1:0] diff;
  logic          ge;

  // multiplier sign bit weighs negative on the last step
  always_comb begin
    if (!mplier[0]) addend = '0;
    else if (cnt == MUL_LAST) addend = -mcand;
    else addend = mcand;
    rem_sh = {rem[AW-1:0], dvd[AW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr};
    ge     = !diff[AW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        op_q   <= req.op;
        cnt    <= '0;
        acc    <= acc_in;
        mcand  <= opa;
        mplier <= opb[MW-1:0];
        dvd    <= opa;
        dsr    <= opb;
        rem    <= '0;
        quo    <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (op_q == ALU_MUL) begin
          acc    <= acc + addend;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          if (cnt == MUL_LAST) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          rem <= ge ? diff[AW:0] : rem_sh;
          quo <= {quo[AW-2:0], ge};
          dvd <= dvd << 1;
          if (cnt == DIV_LAST) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign result = (op_q == ALU_MUL) ? acc : quo;

endmodule

@@ design/two_disk_elastic_collision_step.sv @@
// Two-disk elastic collision step. Keeps position and velocity of disks A
// and B as signed fixed point (VALUE_WIDTH bits, 8 fraction bits). A request
// with func=1 loads the selected disk's state and goes straight to the done
// state. A request with func=0 runs one tick: contact test (squared distance
// against squared radius sum), the mass-weighted elastic velocity update
// along the centre line when in contact (skipped for coincident centres or
// zero total mass), then each position advances by velocity*time_step,
// rounded half away from zero and clipped to range. The squared distance and
// the velocity update run on one shared bit-serial multiply/divide unit; the
// squared radius sum and the position steps use their own multipliers. Most
// of a colliding tick goes to its four divide passes. One request is in work
// at a time; the result sits in an output register, so the next request is
// taken while the previous result waits, and a result that still waits holds
// the following one in its final state. Configuration should be written only
// between requests.
module two_disk_elastic_collision_step #(
  parameter int VALUE_WIDTH = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [tdec_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tdec_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   func,
  input  logic                                   disk_sel,
  input  logic signed [VALUE_WIDTH-1:0]          load_x,
  input  logic signed [VALUE_WIDTH-1:0]          load_y,
  input  logic signed [VALUE_WIDTH-1:0]          load_vx,
  input  logic signed [VALUE_WIDTH-1:0]          load_vy,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [VALUE_WIDTH-1:0]          a_x,
  output logic signed [VALUE_WIDTH-1:0]          a_y,
  output logic signed [VALUE_WIDTH-1:0]          b_x,
  output logic signed [VALUE_WIDTH-1:0]          b_y,
  output logic signed [VALUE_WIDTH-1:0]          a_vx,
  output logic signed [VALUE_WIDTH-1:0]          a_vy,
  output logic signed [VALUE_WIDTH-1:0]          b_vx,
  output logic signed [VALUE_WIDTH-1:0]          b_vy,
  output logic                                   collided,
  output logic                                   saturated
);
  import tdec_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int SW = W + 1;        // differences
  localparam int AW = 3 * W + 24;   // widest product plus rounding headroom
  localparam int MW = W + 2;        // multiplier operand
  localparam int PW = W + 2;        // position update
  localparam int RW = RADIUS_W + 1;

  localparam longint VMAXL = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam longint RST_AY_L = (64'sd51200 > VMAXL) ? VMAXL : 64'sd51200;
  localparam longint RST_BX_L = (64'sd204800 > VMAXL) ? VMAXL : 64'sd204800;
  localparam longint RST_BY_L = (64'sd56320 > VMAXL) ? VMAXL : 64'sd56320;

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [AW-1:0] VMAX_A = {{(AW-W){1'b0}}, VMAX};
  localparam logic signed [AW-1:0] VMIN_A = {{(AW-W){1'b1}}, VMIN};
  localparam logic signed [PW-1:0] VMAX_P = {2'b00, VMAX};
  localparam logic signed [PW-1:0] VMIN_P = {2'b11, VMIN};

  typedef enum logic [3:0] {
    S_IDLE, S_D2X, S_D2Y, S_CHECK, S_DOTX, S_DOTY, S_DEN, S_PX, S_PY,
    S_NUM, S_DIV, S_APPLY, S_ADV, S_DONE
  } state_t;

  state_t state;
  logic   wait_alu;

  // configuration
  logic [MASS_W-1:0]   mass_a, mass_b;
  logic [RADIUS_W-1:0] radius_a, radius_b;
  logic [TSTEP_W-1:0]  time_step;

  // disk state: index {disk, axis}, 0 A.x, 1 A.y, 2 B.x, 3 B.y
  logic signed [W-1:0] pos [4];
  logic signed [W-1:0] vel [4];

  // tick working registers
  logic signed [SW-1:0] sepx, sepy, relx, rely;
  logic [2*RW-1:0]      lim;
  logic [AW-1:0]        d2, dot, den, px, py, num_mag, quot;
  logic                 num_neg;
  logic [1:0]           k;
  logic                 hit, sat;

  // shared unit hookup
  alu_req_t      req;
  logic [AW-1:0] opa, opb, acc_in, alu_res;
  logic          alu_done;

  logic [MASS_W:0] msum;
  logic [RW-1:0]   rsum;
  assign msum = {1'b0, mass_a} + {1'b0, mass_b};
  assign rsum = {1'b0, radius_a} + {1'b0, radius_b};

  function automatic logic [AW-1:0] sx(input logic signed [SW-1:0] v);
    return {{(AW-SW){v[SW-1]}}, v};
  endfunction

  // operand selection for the step in progress
  always_comb begin
    opa    = '0;
    opb    = '0;
    acc_in = '0;
    req.op = ALU_MUL;
    case (state)
      S_D2X:  begin opa = sx(sepx); opb = sx(sepx); end
      S_D2Y:  begin opa = sx(sepy); opb = sx(sepy); acc_in = alu_res; end
      S_DOTX: begin opa = sx(relx); opb = sx(sepx); end
      S_DOTY: begin opa = sx(rely); opb = sx(sepy); acc_in = alu_res; end
      S_DEN:  begin opa = d2; opb = {{(AW-MASS_W-1){1'b0}}, msum}; end
      S_PX:   begin opa = dot; opb = sx(sepx); end
      S_PY:   begin opa = dot; opb = sx(sepy); end
      S_NUM: begin
        // A uses mass_b, B uses mass_a; axis picks px or py
        opa = k[0] ? py : px;
        opb = {{(AW-MASS_W-1){1'b0}}, (k[1] ? mass_a : mass_b), 1'b0};
      end
      S_DIV: begin
        req.op = ALU_DIV;
        opa    = (num_mag << 1) + den;
        opb    = den << 1;
      end
      default: ;
    endcase
    case (state)
      S_D2X, S_D2Y, S_DOTX, S_DOTY, S_DEN, S_PX, S_PY, S_NUM, S_DIV:
        req.start = !wait_alu;
      default: req.start = 1'b0;
    endcase
  end

  tdec_alu #(.AW(AW), .MW(MW)) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .opa    (opa),
    .opb    (opb),
    .acc_in (acc_in),
    .result (alu_res),
    .done   (alu_done)
  );

  // velocity update: v -/+ rounded ratio, then clip
  logic signed [AW-1:0] qs, cur_v, new_v;
  logic                 v_hi, v_lo;
  always_comb begin
    qs    = num_neg ? -signed'(quot) : signed'(quot);
    cur_v = {{(AW-W){vel[k][W-1]}}, vel[k]};
    new_v = k[1] ? cur_v + qs : cur_v - qs;
    v_hi  = new_v > VMAX_A;
    v_lo  = new_v < VMIN_A;
  end

  // position advance: round(|v|*dt/256) with the sign of v, then clip
  logic [W:0]             vmag;
  logic [W+TSTEP_W:0]     prod;
  logic [W:0]             stp;
  logic signed [PW-1:0]   new_p;
  logic                   p_hi, p_lo;
  always_comb begin
    vmag  = vel[k][W-1] ? -{vel[k][W-1], vel[k]} : {vel[k][W-1], vel[k]};
    prod  = {{TSTEP_W{1'b0}}, vmag} * {{(W+1){1'b0}}, time_step}
            + (W+TSTEP_W+1)'(128);
    stp   = prod[W+TSTEP_W:TSTEP_W];
    new_p = vel[k][W-1] ? {{2{pos[k][W-1]}}, pos[k]} - {1'b0, stp}
                        : {{2{pos[k][W-1]}}, pos[k]} + {1'b0, stp};
    p_hi  = new_p > VMAX_P;
    p_lo  = new_p < VMIN_P;
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wait_alu  <= 1'b0;
      out_valid <= 1'b0;
      mass_a    <= MASS_W'(1);
      mass_b    <= MASS_W'(1);
      radius_a  <= RADIUS_W'(12800);
      radius_b  <= RADIUS_W'(12800);
      time_step <= TSTEP_W'(26);
      pos[0]    <= '0;
      pos[1]    <= W'(RST_AY_L);
      pos[2]    <= W'(RST_BX_L);
      pos[3]    <= W'(RST_BY_L);
      vel[0]    <= W'(3584);
      vel[1]    <= '0;
      vel[2]    <= -W'(3584);
      vel[3]    <= '0;
    end else begin
      // a new result in the done state takes the slot instead
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          CFG_MASS_A:    mass_a    <= cfg_data[MASS_W-1:0];
          CFG_MASS_B:    mass_b    <= cfg_data[MASS_W-1:0];
          CFG_RADIUS_A:  radius_a  <= cfg_data[RADIUS_W-1:0];
          CFG_RADIUS_B:  radius_b  <= cfg_data[RADIUS_W-1:0];
          CFG_TIME_STEP: time_step <= cfg_data[TSTEP_W-1:0];
          default: ;
        endcase
      end

      if (req.start) wait_alu <= 1'b1;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            hit <= 1'b0;
            sat <= 1'b0;
            k   <= '0;
            if (func) begin
              pos[{disk_sel, 1'b0}] <= load_x;
              pos[{disk_sel, 1'b1}] <= load_y;
              vel[{disk_sel, 1'b0}] <= load_vx;
              vel[{disk_sel, 1'b1}] <= load_vy;
              state <= S_DONE;
            end else begin
              sepx  <= {pos[0][W-1], pos[0]} - {pos[2][W-1], pos[2]};
              sepy  <= {pos[1][W-1], pos[1]} - {pos[3][W-1], pos[3]};
              relx  <= {vel[0][W-1], vel[0]} - {vel[2][W-1], vel[2]};
              rely  <= {vel[1][W-1], vel[1]} - {vel[3][W-1], vel[3]};
              lim   <= {{RW{1'b0}}, rsum} * {{RW{1'b0}}, rsum};
              state <= S_D2X;
            end
          end
        end
        S_D2X:  if (alu_done) begin wait_alu <= 1'b0; state <= S_D2Y; end
        S_D2Y:  if (alu_done) begin
          wait_alu <= 1'b0; d2 <= alu_res; state <= S_CHECK;
        end
        S_CHECK: begin
          if (d2 <= {{(AW-2*RW){1'b0}}, lim} && d2 != '0 && msum != '0)
            state <= S_DOTX;
          else
            state <= S_ADV;
        end
        S_DOTX: if (alu_done) begin wait_alu <= 1'b0; state <= S_DOTY; end
        S_DOTY: if (alu_done) begin
          wait_alu <= 1'b0; dot <= alu_res; state <= S_DEN;
        end
        S_DEN: if (alu_done) begin
          wait_alu <= 1'b0; den <= alu_res; state <= S_PX;
        end
        S_PX: if (alu_done) begin
          wait_alu <= 1'b0; px <= alu_res; state <= S_PY;
        end
        S_PY: if (alu_done) begin
          wait_alu <= 1'b0; py <= alu_res; state <= S_NUM;
        end
        S_NUM: if (alu_done) begin
          wait_alu <= 1'b0;
          num_neg  <= alu_res[AW-1];
          num_mag  <= alu_res[AW-1] ? -alu_res : alu_res;
          state    <= S_DIV;
        end
        S_DIV: if (alu_done) begin
          wait_alu <= 1'b0; quot <= alu_res; state <= S_APPLY;
        end
        S_APPLY: begin
          vel[k] <= v_hi ? VMAX : (v_lo ? VMIN : new_v[W-1:0]);
          if (v_hi || v_lo) sat <= 1'b1;
          k <= k + 1'b1;
          if (k == 2'd3) begin
            hit   <= 1'b1;
            state <= S_ADV;
          end else begin
            state <= S_NUM;
          end
        end
        S_ADV: begin
          pos[k] <= p_hi ? VMAX : (p_lo ? VMIN : new_p[W-1:0]);
          if (p_hi || p_lo) sat <= 1'b1;
          k <= k + 1'b1;
          if (k == 2'd3) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            a_x       <= pos[0];
            a_y       <= pos[1];
            b_x       <= pos[2];
            b_y       <= pos[3];
            a_vx      <= vel[0];
            a_vy      <= vel[1];
            b_vx      <= vel[2];
            b_vy      <= vel[3];
            collided  <= hit;
            saturated <= sat;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/sv/tb_two_disk_elastic_collision_step.sv @@
`timescale 1ns / 100ps

module tb_two_disk_elastic_collision_step;
  import tdec_pkg::*;

  localparam int VW = 24;
  // no progress for this many cycles means the block hung; the limit
  // covers a colliding tick plus the longest sink stall
  localparam int HANG_LIMIT = 6000;
  // idle time before a register write; covers one colliding tick
  localparam int SETTLE_CYCLES = 800;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;
  localparam logic DISK_A = 1'b0;
  localparam logic DISK_B = 1'b1;

  typedef logic signed [VW-1:0] val_t;
  typedef logic signed [191:0] wide_t;

  localparam val_t VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(VW-1){1'b0}}};

  typedef struct {
    logic func;
    logic sel;
    val_t x, y, vx, vy;
  } req_t;

  // positions and velocities in port order, then the two flags
  typedef struct {
    val_t v[8];
    logic col;
    logic sat;
  } disk_state_t;

  // directed rows: flags are typed in where they are obvious
  typedef struct {
    req_t r;
    bit   known;
    logic col;
    logic sat;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MASS_A;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = FUNC_TICK;
  logic disk_sel = DISK_A;
  val_t load_x = '0, load_y = '0, load_vx = '0, load_vy = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  val_t a_x, a_y, b_x, b_y, a_vx, a_vy, b_vx, b_vy;
  logic collided, saturated;

  always #5 clk = ~clk;

  two_disk_elastic_collision_step #(.VALUE_WIDTH(VW)) dut (.*);

  // ---------------------------------------------------------------
  // Predictor: shadow copy of registers and disk state
  // ---------------------------------------------------------------
  longint m_a, m_b, r_a, r_b, t_step;
  longint px_s[2], py_s[2], vx_s[2], vy_s[2];

  disk_state_t pending[$];
  int errors = 0;
  bit stall_free = 1'b0;

  function automatic longint clip_val(longint v, inout logic sat);
    if (v > longint'(VMAX)) begin
      sat = 1'b1;
      return longint'(VMAX);
    end
    if (v < longint'(VMIN)) begin
      sat = 1'b1;
      return longint'(VMIN);
    end
    return v;
  endfunction

  // round(scale * prod / den), halves away from zero
  function automatic longint round_quot(longint scale, wide_t prod, wide_t den);
    wide_t num, mag, q;
    num = wide_t'(scale) * prod;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint step_pos(longint pos, longint vel, inout logic sat);
    longint mag, stp;
    mag = (vel < 0) ? -vel : vel;
    stp = (mag * t_step + 128) >>> 8;
    return clip_val((vel < 0) ? pos - stp : pos + stp, sat);
  endfunction

  function automatic disk_state_t apply_request(req_t r);
    disk_state_t e;
    longint sx, sy, rx, ry, rs, ms;
    wide_t wx, wy, d2, dotp, den, prx, pry;
    longint nax, nay, nbx, nby;
    int d;
    e.col = 1'b0;
    e.sat = 1'b0;
    if (r.func == FUNC_LOAD) begin
      d = (r.sel == DISK_B) ? 1 : 0;
      px_s[d] = r.x;
      py_s[d] = r.y;
      vx_s[d] = r.vx;
      vy_s[d] = r.vy;
    end else begin
      sx = px_s[0] - px_s[1];
      sy = py_s[0] - py_s[1];
      rx = vx_s[0] - vx_s[1];
      ry = vy_s[0] - vy_s[1];
      wx = sx;
      wy = sy;
      d2 = wx * wx + wy * wy;
      rs = r_a + r_b;
      ms = m_a + m_b;
      // contact, not coincident, nonzero total mass
      if (d2 <= wide_t'(rs * rs) && d2 != 0 && ms != 0) begin
        dotp = wide_t'(rx) * wx + wide_t'(ry) * wy;
        den = wide_t'(ms) * d2;
        prx = dotp * wx;
        pry = dotp * wy;
        nax = vx_s[0] - round_quot(2 * m_b, prx, den);
        nay = vy_s[0] - round_quot(2 * m_b, pry, den);
        nbx = vx_s[1] + round_quot(2 * m_a, prx, den);
        nby = vy_s[1] + round_quot(2 * m_a, pry, den);
        vx_s[0] = clip_val(nax, e.sat);
        vy_s[0] = clip_val(nay, e.sat);
        vx_s[1] = clip_val(nbx, e.sat);
        vy_s[1] = clip_val(nby, e.sat);
        e.col = 1'b1;
      end
      for (int k = 0; k < 2; k++) begin
        px_s[k] = step_pos(px_s[k], vx_s[k], e.sat);
        py_s[k] = step_pos(py_s[k], vy_s[k], e.sat);
      end
    end
    e.v[0] = val_t'(px_s[0]);
    e.v[1] = val_t'(py_s[0]);
    e.v[2] = val_t'(px_s[1]);
    e.v[3] = val_t'(py_s[1]);
    e.v[4] = val_t'(vx_s[0]);
    e.v[5] = val_t'(vy_s[0]);
    e.v[6] = val_t'(vx_s[1]);
    e.v[7] = val_t'(vy_s[1]);
    return e;
  endfunction

  // ---------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------
  int in_gap_long_pct = 3;

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 100 - in_gap_long_pct) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // called at a rising edge; returns at the edge that accepted the request
  task automatic send_request(req_t r, int gap, bit known = 0,
                              logic k_col = 0, logic k_sat = 0);
    disk_state_t e;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= r.func;
    disk_sel <= r.sel;
    load_x <= r.x;
    load_y <= r.y;
    load_vx <= r.vx;
    load_vy <= r.vy;
    // ready is decided away from the edge, so sample on the falling edge
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    e = apply_request(r);
    if (known) begin
      e.col = k_col;
      e.sat = k_sat;
    end
    pending.push_back(e);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    case (idx)
      CFG_MASS_A:    m_a = value & 16'hFFFF;
      CFG_MASS_B:    m_b = value & 16'hFFFF;
      CFG_RADIUS_A:  r_a = value & 23'h7FFFFF;
      CFG_RADIUS_B:  r_b = value & 23'h7FFFFF;
      CFG_TIME_STEP: t_step = value & 8'hFF;
      default: ;
    endcase
  endtask

  // block must be idle: all results in, plus settle time
  task automatic configure(longint ma, longint mb, longint ra, longint rb, longint ts);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_MASS_A, ma);
    write_reg(CFG_MASS_B, mb);
    write_reg(CFG_RADIUS_A, ra);
    write_reg(CFG_RADIUS_B, rb);
    write_reg(CFG_TIME_STEP, ts);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic val_t near(longint center, int spread);
    return val_t'(center + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // mostly close disks with random state so contact happens often;
  // some fully random loads reach every bit and the clip paths
  function automatic req_t random_request(longint span);
    req_t r;
    int p;
    p = $urandom_range(99);
    r.func = (p < 50) ? FUNC_TICK : FUNC_LOAD;
    r.sel = $urandom_range(1);
    if (p < 85) begin
      r.x = near(r.sel ? span : 0, int'(span));
      r.y = near(0, int'(span));
      r.vx = near(0, 6000);
      r.vy = near(0, 6000);
    end else begin
      r.x = val_t'($urandom);
      r.y = val_t'($urandom);
      r.vx = val_t'($urandom);
      r.vy = val_t'($urandom);
    end
    return r;
  endfunction

  task automatic random_phase(int n, longint span);
    req_t r;
    for (int i = 0; i < n; i++) begin
      r = random_request(span);
      // sender holds off once until the pipe is empty
      if (i == n / 2) drain();
      send_request(r, pick_gap());
    end
  endtask

  row_t dir_rows[15] = '{
    '{'{FUNC_TICK, DISK_A, 0, 0, 0, 0}, 0, 0, 0},
    '{'{FUNC_LOAD, DISK_A, 0, 0, 256, 0}, 1, 0, 0},
    '{'{FUNC_LOAD, DISK_B, 0, 0, 0, 0}, 1, 0, 0},
    // coincident centres: no update
    '{'{FUNC_TICK, DISK_A, 0, 0, 0, 0}, 1, 0, 0},
    '{'{FUNC_LOAD, DISK_A, VMAX, VMAX, VMAX, VMAX}, 1, 0, 0},
    // far apart, position clips high
    '{'{FUNC_TICK, DISK_B, 0, 0, 0, 0}, 1, 0, 1},
    '{'{FUNC_LOAD, DISK_A, VMIN, VMIN, VMIN, VMIN}, 1, 0, 0},
    '{'{FUNC_TICK, DISK_A, 0, 0, 0, 0}, 1, 0, 1},
    // head-on contact
    '{'{FUNC_LOAD, DISK_A, 0, 0, 256, 0}, 1, 0, 0},
    '{'{FUNC_LOAD, DISK_B, 5120, 0, -256, 0}, 1, 0, 0},
    '{'{FUNC_TICK, DISK_A, 0, 0, 0, 0}, 1, 1, 0},
    // oblique contact
    '{'{FUNC_LOAD, DISK_B, 3000, 4000, -512, 300}, 0, 0, 0},
    '{'{FUNC_TICK, DISK_B, 0, 0, 0, 0}, 0, 0, 0},
    '{'{FUNC_LOAD, DISK_B, 24'sh5A5A5A, -24'sh25A5A5, 24'sh2A5A5A, -24'sh35A5A6}, 0, 0, 0},
    '{'{FUNC_TICK, DISK_A, 0, 0, 0, 0}, 0, 0, 0}
  };

  // ---------------------------------------------------------------
  // Result side: random backpressure
  // ---------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!stall_free && $urandom_range(99) < 25) begin
      stall_left <= ($urandom_range(99) < 4) ? $urandom_range(30, 200)
                                             : $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare on the falling edge; the transfer completes at the next rise
  string field_names[8] = '{"a_x", "a_y", "b_x", "b_y", "a_vx", "a_vy", "b_vx", "b_vy"};
  int idle_count = 0;

  always @(negedge clk) begin
    disk_state_t e;
    val_t got[8];
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= HANG_LIMIT) begin
        $display("** two_disk_elastic_collision_step: FAILED **");
        $finish;
      end
    end
    if (!rst && out_valid && out_ready) begin
      got = '{a_x, a_y, b_x, b_y, a_vx, a_vy, b_vx, b_vy};
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending.pop_front();
        for (int k = 0; k < 8; k++)
          if (got[k] !== e.v[k]) begin
            $error("%s: expected %0d, got %0d", field_names[k], e.v[k], got[k]);
            errors++;
          end
        if (collided !== e.col) begin
          $error("collided: expected %0b, got %0b", e.col, collided);
          errors++;
        end
        if (saturated !== e.sat) begin
          $error("saturated: expected %0b, got %0b", e.sat, saturated);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin
    m_a = 1;
    m_b = 1;
    r_a = 12800;
    r_b = 12800;
    t_step = 26;
    px_s = '{0, 204800};
    py_s = '{51200, 56320};
    vx_s = '{3584, -3584};
    vy_s = '{0, 0};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_request(dir_rows[i].r, pick_gap(), dir_rows[i].known,
                   dir_rows[i].col, dir_rows[i].sat);

    random_phase(150, 20000);

    // extremes: lopsided masses, huge radii, longest step, no stalls
    stall_free = 1'b1;
    in_gap_long_pct = 0;
    configure(1, 65535, 8388607, 8388607, 255);
    random_phase(200, 40000);

    // zero total mass, zero radii, zero step
    stall_free = 1'b0;
    in_gap_long_pct = 5;
    configure(0, 0, 0, 0, 0);
    random_phase(150, 20000);

    // heavy equal masses, radii just touching, mid step
    configure(65535, 65535, 10000, 0, 128);
    random_phase(200, 8000);

    // random settings
    configure($urandom_range(1, 65535), $urandom_range(1, 65535),
              $urandom_range(0, 30000), $urandom_range(0, 30000),
              $urandom_range(0, 255));
    random_phase(200, 25000);

    configure(65535, 1, 0, 8388607, 1);
    random_phase(200, 30000);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("** two_disk_elastic_collision_step: PASSED **");
    end else begin
      $display("** two_disk_elastic_collision_step: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/tdec_pkg.sv
design/tdec_alu.sv
design/two_disk_elastic_collision_step.sv
tb/sv/tb_two_disk_elastic_collision_step.sv
